/* src/hcbp_pkg.sv */
// Shared constants and types for the Huffman code bit packer.
package hcbp_pkg;

  localparam int SYMBOL_COUNT  = 256;
  localparam int MAX_CODE_BITS = 32;

  localparam int SYM_W    = 8;
  localparam int SYM_AW   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int ACC_W    = 8;
  localparam int FILL_W   = 3;
  localparam int TOTAL_W  = 32;
  localparam int CODE_CAP = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
  localparam int COMB_W   = ACC_W + CODE_W;

  // A code plus a partial byte spans at most this many full bytes.
  localparam int MAX_BYTES = (CODE_CAP + ACC_W - 1) / ACC_W;
  localparam int BYTE_IW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAX_BYTES + 2);

  localparam logic [SYM_W:0]     SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
  localparam logic [LEN_W-1:0]   LEN_CAP   = LEN_W'(CODE_CAP);

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ENCODE = 2'd1;
  localparam logic [1:0] FUNC_END    = 2'd2;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [1:0]         func;
    logic               hit;
    logic [LEN_W-1:0]   len;
    logic [CODE_W-1:0]  code;
  } lookup_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][ACC_W-1:0] data;
    logic [CNT_W-1:0]                nbytes;
    logic                            summary;
    logic [TOTAL_W-1:0]              total;
  } group_t;

endpackage

/* src/hcbp_table.sv */
// Code table memory, symbol valid marks and the lookup stage register.
module hcbp_table import hcbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        func,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [CODE_W-1:0] code_value,
  input  logic [LEN_W-1:0]  code_length,
  input  logic              take,
  output lookup_t           lk
);

  logic [LEN_W+CODE_W-1:0] mem [SYMBOL_COUNT];
  logic [LEN_W+CODE_W-1:0] rdata;
  logic [SYMBOL_COUNT-1:0] marks;
  logic                    s1_valid;
  logic                    s1_hit;
  logic [1:0]              s1_func;

  logic              in_range;
  logic [SYM_AW-1:0] addr;
  logic [LEN_W-1:0]  len_sat;
  logic              we;
  logic              re;

  assign in_range = {1'b0, symbol} < SYM_LIMIT;
  assign addr     = symbol[SYM_AW-1:0];
  assign len_sat  = (code_length > LEN_CAP) ? LEN_CAP : code_length;
  assign we       = accept && (func == FUNC_LOAD) && in_range;
  assign re       = accept && (func == FUNC_ENCODE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= {len_sat, code_value};
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '0;
    end else if (accept) begin
      case (func)
        FUNC_LOAD: begin
          if (in_range) begin
            marks[addr] <= 1'b1;
          end
        end
        FUNC_END: marks <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func <= func;
      s1_hit  <= (func == FUNC_ENCODE) && in_range && marks[addr];
    end
  end

  assign lk.valid = s1_valid;
  assign lk.func  = s1_func;
  assign lk.hit   = s1_hit;
  assign lk.len   = rdata[LEN_W+CODE_W-1:CODE_W];
  assign lk.code  = rdata[CODE_W-1:0];

endmodule

/* src/hcbp_packer.sv */
// Bit accumulator: merges looked-up codes into bytes and builds result groups.
module hcbp_packer import hcbp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  lookup_t lk,
  input  logic    grp_free,
  output logic    take,
  output group_t  grp
);

  logic [ACC_W-1:0]   acc;
  logic [FILL_W-1:0]  fill;
  logic [TOTAL_W-1:0] total;

  logic [ACC_W-1:0]   acc_next;
  logic [FILL_W-1:0]  fill_next;
  logic [TOTAL_W-1:0] total_next;

  logic [LEN_W-1:0]   bits;
  logic [CNT_W-1:0]   nb;
  logic [FILL_W-1:0]  rem_fill;
  logic [CODE_W-1:0]  code_al;
  logic [ACC_W-1:0]   acc_al;
  logic [COMB_W-1:0]  comb;
  logic [COMB_W-1:0]  rest;
  logic [MAX_BYTES-1:0][ACC_W-1:0] bytes;

  assign take = lk.valid && grp_free;

  always_comb begin
    bits     = LEN_W'(fill) + lk.len;
    nb       = CNT_W'(bits >> $clog2(ACC_W));
    rem_fill = bits[FILL_W-1:0];
    // Left-align the code and the partial byte, then butt them together.
    code_al  = lk.code << (LEN_W'(CODE_W) - lk.len);
    acc_al   = acc << (4'(ACC_W) - 4'(fill));
    comb     = {acc_al, {CODE_W{1'b0}}} | ({code_al, {ACC_W{1'b0}}} >> fill);
    rest     = comb << (LEN_W'(nb) << $clog2(ACC_W));
    for (int k = 0; k < MAX_BYTES; k++) begin
      bytes[k] = comb[COMB_W-1-ACC_W*k -: ACC_W];
    end
  end

  always_comb begin
    acc_next    = acc;
    fill_next   = fill;
    total_next  = total;
    grp.data    = bytes;
    grp.nbytes  = '0;
    grp.summary = 1'b0;
    grp.total   = total;
    case (lk.func)
      FUNC_ENCODE: begin
        if (lk.hit) begin
          grp.nbytes = nb;
          acc_next   = rest[COMB_W-1 -: ACC_W] >> (4'(ACC_W) - 4'(rem_fill));
          fill_next  = rem_fill;
          total_next = total + TOTAL_W'(lk.len);
        end
      end
      FUNC_END: begin
        // Pad the partial byte with zeros and close the stream.
        grp.data[0] = acc_al;
        grp.nbytes  = (fill != '0) ? CNT_W'(1) : '0;
        grp.summary = 1'b1;
        acc_next    = '0;
        fill_next   = '0;
        total_next  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      fill  <= '0;
      total <= '0;
    end else if (take) begin
      acc   <= acc_next;
      fill  <= fill_next;
      total <= total_next;
    end
  end

endmodule

/* src/hcbp_out.sv */
// Result group register: drains data bytes and the summary one transaction at a time.
module hcbp_out import hcbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               grp_load,
  input  group_t             grp,
  output logic               grp_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [ACC_W-1:0]   packed_byte,
  output logic [TOTAL_W-1:0] bit_count,
  output logic               last_of_run
);

  group_t           held;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] ptr;
  logic             fire;

  assign fire      = out_valid && out_ready;
  assign out_valid = (rem != '0);
  assign grp_free  = (rem == '0) || ((rem == CNT_W'(1)) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      ptr <= '0;
    end else if (grp_load) begin
      rem <= grp.nbytes + CNT_W'(grp.summary);
      ptr <= '0;
    end else if (fire) begin
      rem <= rem - CNT_W'(1);
      ptr <= ptr + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      held <= grp;
    end
  end

  always_comb begin
    out_kind    = (ptr < held.nbytes) ? KIND_DATA : KIND_SUMMARY;
    packed_byte = (out_kind == KIND_DATA) ? held.data[ptr[BYTE_IW-1:0]] : '0;
    bit_count   = (out_kind == KIND_SUMMARY) ? held.total : '0;
    last_of_run = (rem == CNT_W'(1));
  end

endmodule

/* src/huffman_code_bit_packer_top.sv */
// Huffman code bit packer: code table load, MSB-first packing and end-of-stream flush.
//
// Input channel (in_valid/in_ready) takes one item per transaction: func selects
// load (write a symbol's code and length), encode (look up a symbol and append its
// code bits) or end (pad and emit the partial byte, report the bit total, clear).
// Output channel (out_valid/out_ready) returns results one per transaction:
// packed data bytes (out_kind 0) and the end summary (out_kind 1); last_of_run
// marks the final result of an item. Loads, unknown symbols and zero-length codes
// give no result.
// The table read registers when an item is accepted, and the packing stage loads
// the output group register once it frees, so each result of an item passes the
// lookup register and then the output group register before it is offered.
// Throughput: one item per cycle as long as each item yields at most one result
// and the receiver does not stall; an item with k results (up to 4) holds the output
// group register until all k have drained, and that register is what paces the input.
// Reset clears the valid marks, bit accumulator, fill count and bit total; the
// code table keeps no reset and needs no clearing pass.
// When the receiver stalls, the current result holds, the next item waits in the
// lookup register, and in_ready drops until the group register frees.
module huffman_code_bit_packer_top import hcbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [CODE_W-1:0]  code_value,
  input  logic [LEN_W-1:0]   code_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [ACC_W-1:0]   packed_byte,
  output logic [TOTAL_W-1:0] bit_count,
  output logic               last_of_run
);

  lookup_t lk;
  group_t  grp;
  logic    take;
  logic    grp_free;
  logic    accept;

  assign in_ready = !lk.valid || take;
  assign accept   = in_valid && in_ready;

  hcbp_table u_table (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (func),
    .symbol      (symbol),
    .code_value  (code_value),
    .code_length (code_length),
    .take        (take),
    .lk          (lk)
  );

  hcbp_packer u_packer (
    .clk      (clk),
    .rst      (rst),
    .lk       (lk),
    .grp_free (grp_free),
    .take     (take),
    .grp      (grp)
  );

  hcbp_out u_out (
    .clk         (clk),
    .rst         (rst),
    .grp_load    (take),
    .grp         (grp),
    .grp_free    (grp_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .packed_byte (packed_byte),
    .bit_count   (bit_count),
    .last_of_run (last_of_run)
  );

endmodule

/* src/hcbp_checker.sv */
// Port-level checks for the Huffman code bit packer, bound to the top level.
module hcbp_checker import hcbp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_kind,
  input logic [ACC_W-1:0]   packed_byte,
  input logic [TOTAL_W-1:0] bit_count,
  input logic               last_of_run
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(packed_byte)
      && $stable(bit_count) && $stable(last_of_run))
    else $error("stalled result changed");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_SUMMARY) |-> last_of_run && (packed_byte == '0))
    else $error("summary not last or carries a byte");

  a_data_no_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_DATA) |-> (bit_count == '0))
    else $error("data byte carries a bit count");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind huffman_code_bit_packer_top hcbp_checker u_hcbp_checker (.*);

/* tb/huffman_code_bit_packer_top_test.sv */
// Self-checking testbench for the Huffman code bit packer: table loads, MSB-first packing, flush.
module huffman_code_bit_packer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hcbp_pkg::*;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         RUN_LIMIT    = 200000;
  localparam int         RANDOM_ITEMS = 210;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         PRINT_LIMIT  = 40;

  typedef struct {
    logic               kind;
    logic [ACC_W-1:0]   data_byte;
    logic [TOTAL_W-1:0] count;
    logic               last;
  } packer_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         func;
  logic [SYM_W-1:0]   symbol;
  logic [CODE_W-1:0]  code_value;
  logic [LEN_W-1:0]   code_length;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_kind;
  logic [ACC_W-1:0]   packed_byte;
  logic [TOTAL_W-1:0] bit_count;
  logic               last_of_run;

  // predicted packer state
  logic [CODE_W-1:0]  code_tab [SYMBOL_COUNT];
  logic [LEN_W-1:0]   len_tab [SYMBOL_COUNT];
  bit                 sym_known [SYMBOL_COUNT];
  logic [ACC_W-1:0]   acc_bits;
  int                 acc_fill;
  logic [TOTAL_W-1:0] bits_total;

  packer_result_t     packed_q [$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 items_sent = 0;

  // sender and receiver idling profile
  int                 tx_burst_max = 0;
  int                 tx_gap_max = 0;
  int                 burst_left = 0;
  int                 rx_stall_max = 0;
  int                 rx_hold = 0;

  always #2 clk = ~clk;

  huffman_code_bit_packer_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .symbol      (symbol),
    .code_value  (code_value),
    .code_length (code_length),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .packed_byte (packed_byte),
    .bit_count   (bit_count),
    .last_of_run (last_of_run)
  );

  function automatic void clear_stream_state();
    for (int s = 0; s < SYMBOL_COUNT; s++) sym_known[s] = 1'b0;
    acc_bits   = '0;
    acc_fill   = 0;
    bits_total = '0;
  endfunction

  function automatic void predict_packing(input logic [1:0] f, input logic [SYM_W-1:0] sym,
                                          input logic [CODE_W-1:0] code,
                                          input logic [LEN_W-1:0] len);
    int             n_out = 0;
    int             nbits;
    logic [ACC_W-1:0] padded;
    packer_result_t r;
    case (f)
      FUNC_LOAD: begin
        if (int'(sym) < SYMBOL_COUNT) begin
          code_tab[sym]  = code;
          len_tab[sym]   = (len > LEN_CAP) ? LEN_CAP : len;
          sym_known[sym] = 1'b1;
        end
      end
      FUNC_ENCODE: begin
        if (int'(sym) < SYMBOL_COUNT && sym_known[sym]) begin
          nbits = int'(len_tab[sym]);
          for (int i = nbits - 1; i >= 0; i--) begin
            acc_bits = {acc_bits[ACC_W-2:0], code_tab[sym][i]};
            acc_fill++;
            if (acc_fill == ACC_W) begin
              r = '{KIND_DATA, acc_bits, '0, 1'b0};
              packed_q.push_back(r);
              n_out++;
              acc_bits = '0;
              acc_fill = 0;
            end
          end
          bits_total += TOTAL_W'(nbits);
          if (n_out > 0) packed_q[packed_q.size()-1].last = 1'b1;
        end
      end
      FUNC_END: begin
        if (acc_fill > 0) begin
          padded = acc_bits << (ACC_W - acc_fill);
          r = '{KIND_DATA, padded, '0, 1'b0};
          packed_q.push_back(r);
        end
        r = '{KIND_SUMMARY, '0, bits_total, 1'b1};
        packed_q.push_back(r);
        clear_stream_state();
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  // predict on each accepted item, then check each accepted result
  always @(posedge clk) begin : check_results
    packer_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) predict_packing(func, symbol, code_value, code_length);
      if (out_valid && out_ready) begin
        if (packed_q.size() == 0) begin
          report_mismatch("result with nothing pending, byte", 32'(packed_byte), 0);
        end else begin
          want = packed_q.pop_front();
          if (out_kind !== want.kind)
            report_mismatch("out_kind", 32'(out_kind), 32'(want.kind));
          if (packed_byte !== want.data_byte)
            report_mismatch("packed_byte", 32'(packed_byte), 32'(want.data_byte));
          if (bit_count !== want.count) report_mismatch("bit_count", bit_count, want.count);
          if (last_of_run !== want.last)
            report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
        end
      end
    end
  end

  // receiver: random stall runs of bounded length
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (rx_stall_max > 0 && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_hold = $urandom_range(0, rx_stall_max - 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, packed_q.size());
      $display("** huffman_code_bit_packer_top: FAILED **");
      $finish;
    end
  end

  task automatic set_idling(input int burst, input int gap, input int stall);
    tx_burst_max = burst;
    tx_gap_max   = gap;
    rx_stall_max = stall;
    burst_left   = 0;
  endtask

  // drive one transaction and hold it until accepted; keep valid high inside a burst
  task automatic send_item(input logic [1:0] f, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
    in_valid    <= 1'b1;
    func        <= f;
    symbol      <= sym;
    code_value  <= code;
    code_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (tx_gap_max > 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, tx_gap_max)) @(posedge clk);
      burst_left = $urandom_range(0, tx_burst_max);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (packed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int r = $urandom_range(0, 99);
    if (r < 70) return LEN_W'($urandom_range(1, 12));
    if (r < 80) return '0;
    if (r < 95) return LEN_W'($urandom_range(13, 32));
    return LEN_W'($urandom_range(33, 63));
  endfunction

  task automatic test_directed_cases();
    set_idling(0, 0, 0);
    send_item(FUNC_LOAD, 8'd0, 32'h0, 6'd0);            // zero-length code
    send_item(FUNC_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
    send_item(FUNC_LOAD, 8'd7, 32'h5, 6'd3);
    send_item(FUNC_LOAD, 8'd128, 32'hAAAA_AAAA, 6'd63); // overlong, saturates
    send_item(FUNC_LOAD, 8'd3, 32'hFFFF_FFF0, 6'd5);    // bits above length ignored
    send_item(FUNC_LOAD, 8'd200, 32'hC3, 6'd8);
    send_item(FUNC_ENCODE, 8'd0, 32'h0, 6'd0);
    send_item(FUNC_ENCODE, 8'd255, 32'h0, 6'd0);
    send_item(FUNC_ENCODE, 8'd7, 32'h0, 6'd0);
    send_item(FUNC_ENCODE, 8'd128, 32'h0, 6'd0);
    send_item(FUNC_ENCODE, 8'd9, 32'hFFFF_FFFF, 6'h3F); // unknown symbol
    send_item(FUNC_UNUSED, 8'd7, 32'hFFFF_FFFF, 6'h3F);
    send_item(FUNC_ENCODE, 8'd3, 32'h0, 6'd0);
    send_item(FUNC_ENCODE, 8'd200, 32'h0, 6'd0);
    send_item(FUNC_ENCODE, 8'd7, 32'h0, 6'd0);
    send_item(FUNC_END, 8'd0, 32'h0, 6'd0);             // partial byte flush
    send_item(FUNC_END, 8'd255, 32'hFFFF_FFFF, 6'h3F);  // empty accumulator
    send_item(FUNC_ENCODE, 8'd7, 32'h0, 6'd0);          // mark cleared by end
    send_item(FUNC_LOAD, 8'd7, 32'h1, 6'd1);            // reload
    send_item(FUNC_ENCODE, 8'd7, 32'h0, 6'd0);
    send_item(FUNC_LOAD, 8'd255, 32'h8000_0001, 6'd32);
    send_item(FUNC_ENCODE, 8'd255, 32'h0, 6'd0);
    send_item(FUNC_END, 8'd0, 32'h0, 6'd0);
    wait_drained();
  endtask

  // back-to-back long codes against a slow receiver, then the reverse
  task automatic test_backpressure();
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 0) set_idling(0, 0, 10);
      else set_idling(1, 8, 0);
      for (int s = 0; s < 4; s++)
        send_item(FUNC_LOAD, SYM_W'(s + 16), $urandom, LEN_W'(32 - s));
      for (int k = 0; k < 12; k++)
        send_item(FUNC_ENCODE, SYM_W'($urandom_range(16, 19)), $urandom, LEN_W'($urandom));
      send_item(FUNC_END, SYM_W'($urandom), $urandom, LEN_W'($urandom));
      wait_drained();
    end
  endtask

  // well-formed streams with random content, mixed with unknown symbols and noise
  task automatic test_random_streams();
    logic [SYM_W-1:0] loaded [$];
    logic [SYM_W-1:0] sym;
    int               stop_at;
    int               r;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 2))
        0: set_idling(0, 0, 0);
        1: set_idling(8, 3, 3);
        default: set_idling(2, 6, 8);
      endcase
      loaded.delete();
      repeat ($urandom_range(1, 10)) begin
        sym = SYM_W'($urandom);
        send_item(FUNC_LOAD, sym, $urandom, pick_length());
        loaded.push_back(sym);
      end
      repeat ($urandom_range(4, 24)) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          sym = loaded[$urandom_range(0, loaded.size() - 1)];
          send_item(FUNC_ENCODE, sym, $urandom, LEN_W'($urandom));
        end else if (r < 92) begin
          send_item(FUNC_ENCODE, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        end else if (r < 96) begin
          sym = SYM_W'($urandom);
          send_item(FUNC_LOAD, sym, $urandom, pick_length());
          loaded.push_back(sym);
        end else begin
          send_item(FUNC_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        end
      end
      // leave some streams open so the next one continues the accumulator
      if ($urandom_range(0, 9) != 0)
        send_item(FUNC_END, SYM_W'($urandom), $urandom, LEN_W'($urandom));
    end
    send_item(FUNC_END, '0, '0, '0);
    wait_drained();
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    func        <= FUNC_LOAD;
    symbol      <= '0;
    code_value  <= '0;
    code_length <= '0;
    for (int s = 0; s < SYMBOL_COUNT; s++) begin
      code_tab[s] = '0;
      len_tab[s]  = '0;
    end
    clear_stream_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_backpressure();
    test_random_streams();

    if (mismatch_count == 0) begin
      $display("** huffman_code_bit_packer_top: PASSED **");
    end else begin
      $display("** huffman_code_bit_packer_top: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
src/hcbp_pkg.sv
src/hcbp_table.sv
src/hcbp_packer.sv
src/hcbp_out.sv
src/huffman_code_bit_packer_top.sv
src/hcbp_checker.sv
tb/huffman_code_bit_packer_top_test.sv
